>>> rtl/pic_pkg.sv
package pic_pkg;

	localparam int NUM_SOURCES = 28;
	localparam int SRC_IDX_W   = 5;
	localparam int LEVEL_W     = 4;
	localparam int CODE_W      = 12;
	localparam int PRIO_W      = 16;
	localparam int CFG_IDX_W   = 2;

	// The winner search runs as a registered two-level tree.
	localparam int NUM_GROUPS  = 4;
	localparam int GROUP_SIZE  = NUM_SOURCES / NUM_GROUPS;

	localparam logic [NUM_SOURCES-1:0] ENABLE_RESET = '1;

	typedef enum logic [2:0] {
		CMD_RAISE   = 3'd0,
		CMD_CLEAR   = 3'd1,
		CMD_ENABLE  = 3'd2,
		CMD_DISABLE = 3'd3,
		CMD_EVAL    = 3'd4
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] CFG_PRIO_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIO_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRIO_C = 2'd2;

	// Priority source selectors.
	localparam logic [1:0] SEL_FIXED = 2'd0;
	localparam logic [1:0] SEL_A     = 2'd1;
	localparam logic [1:0] SEL_B     = 2'd2;
	localparam logic [1:0] SEL_C     = 2'd3;

	typedef struct packed {
		logic [2:0]           command;
		logic [SRC_IDX_W-1:0] source;
		logic [LEVEL_W-1:0]   level_mask;
		logic                 block;
	} in_item_t;

	typedef struct packed {
		logic                 accept;
		logic [CODE_W-1:0]    event_code;
		logic [SRC_IDX_W-1:0] winner;
		logic [LEVEL_W-1:0]   winner_level;
	} out_item_t;

	typedef struct packed {
		logic load_item;
		logic eval_groups;
		logic load_result;
	} pic_cmd_t;

	localparam logic [1:0] SRC_SEL [NUM_SOURCES] = '{
		SEL_FIXED, SEL_FIXED, SEL_FIXED,
		SEL_C,
		SEL_C,
		SEL_C, SEL_C, SEL_C, SEL_C, SEL_C,
		SEL_A, SEL_A, SEL_A, SEL_A,
		SEL_A, SEL_A, SEL_A,
		SEL_B, SEL_B, SEL_B, SEL_B,
		SEL_C, SEL_C, SEL_C, SEL_C,
		SEL_B,
		SEL_B,
		SEL_A
	};

	// Fixed level for external lines, field number otherwise.
	localparam logic [LEVEL_W-1:0] SRC_ARG [NUM_SOURCES] = '{
		4'd6, 4'd4, 4'd2,
		4'd0,
		4'd3,
		4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
		4'd3, 4'd2, 4'd1, 4'd1,
		4'd0, 4'd0, 4'd0,
		4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd1, 4'd1, 4'd1,
		4'd3,
		4'd2,
		4'd2
	};

	localparam logic [CODE_W-1:0] SRC_CODE [NUM_SOURCES] = '{
		12'h320, 12'h360, 12'h3A0,
		12'h600,
		12'h620,
		12'h640, 12'h660, 12'h680, 12'h6A0, 12'h6C0,
		12'h400, 12'h420, 12'h440, 12'h460,
		12'h480, 12'h4A0, 12'h4C0,
		12'h4E0, 12'h500, 12'h520, 12'h540,
		12'h700, 12'h720, 12'h740, 12'h760,
		12'h560,
		12'h580,
		12'h5A0
	};

	function automatic logic [LEVEL_W-1:0] src_level(
		input int                idx,
		input logic [PRIO_W-1:0] prio_a,
		input logic [PRIO_W-1:0] prio_b,
		input logic [PRIO_W-1:0] prio_c
	);
		logic [PRIO_W-1:0]  prio_v;
		logic [LEVEL_W-1:0] arg;
		arg = SRC_ARG[idx];
		case (SRC_SEL[idx])
			SEL_A:   prio_v = prio_a;
			SEL_B:   prio_v = prio_b;
			SEL_C:   prio_v = prio_c;
			default: prio_v = '0;
		endcase
		if (SRC_SEL[idx] == SEL_FIXED) begin
			return arg;
		end
		return prio_v[{arg[1:0], 2'b00} +: LEVEL_W];
	endfunction

endpackage

>>> rtl/pic_ctrl.sv
module pic_ctrl import pic_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_ready,
	output logic     out_valid,
	output pic_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_GROUP = 3'b010,
		ST_FINAL = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	assign cmd.load_item   = in_valid && in_ready;
	assign cmd.eval_groups = (state_q == ST_GROUP);
	assign cmd.load_result = (state_q == ST_FINAL) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load_item) begin
					state_d = ST_GROUP;
				end
			end
			ST_GROUP: state_d = ST_FINAL;
			ST_FINAL: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/pic_datapath.sv
module pic_datapath import pic_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pic_cmd_t             cmd,
	input  in_item_t             in_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PRIO_W-1:0]    cfg_data,
	output out_item_t            out_data
);

	logic [PRIO_W-1:0]      prio_a_q;
	logic [PRIO_W-1:0]      prio_b_q;
	logic [PRIO_W-1:0]      prio_c_q;
	logic [NUM_SOURCES-1:0] pending_q;
	logic [NUM_SOURCES-1:0] enable_q;
	logic [LEVEL_W-1:0]     mask_q;
	logic                   block_q;

	logic [NUM_SOURCES-1:0] active;
	logic [LEVEL_W-1:0]     level [NUM_SOURCES];

	logic                   grp_found [NUM_GROUPS];
	logic [LEVEL_W-1:0]     grp_lvl   [NUM_GROUPS];
	logic [SRC_IDX_W-1:0]   grp_idx   [NUM_GROUPS];
	logic                   grp_found_s1 [NUM_GROUPS];
	logic [LEVEL_W-1:0]     grp_lvl_s1   [NUM_GROUPS];
	logic [SRC_IDX_W-1:0]   grp_idx_s1   [NUM_GROUPS];

	logic                   fin_found;
	logic [LEVEL_W-1:0]     fin_lvl;
	logic [SRC_IDX_W-1:0]   fin_idx;
	out_item_t              result;
	out_item_t              out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_a_q <= '0;
			prio_b_q <= '0;
			prio_c_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRIO_A: prio_a_q <= cfg_data;
				CFG_PRIO_B: prio_b_q <= cfg_data;
				CFG_PRIO_C: prio_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The bit update lands with the input transfer; out-of-range sources only evaluate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			enable_q  <= ENABLE_RESET;
		end else if (cmd.load_item && (in_data.source < SRC_IDX_W'(NUM_SOURCES))) begin
			case (in_data.command)
				CMD_RAISE:   pending_q[in_data.source] <= 1'b1;
				CMD_CLEAR:   pending_q[in_data.source] <= 1'b0;
				CMD_ENABLE:  enable_q[in_data.source]  <= 1'b1;
				CMD_DISABLE: enable_q[in_data.source]  <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mask_q  <= in_data.level_mask;
			block_q <= in_data.block;
		end
	end

	assign active = pending_q & enable_q;

	always_comb begin
		for (int i = 0; i < NUM_SOURCES; i++) begin
			level[i] = src_level(i, prio_a_q, prio_b_q, prio_c_q);
		end
	end

	// First tree level: best source within each group, later index wins ties.
	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_found[g] = 1'b0;
			grp_lvl[g]   = '0;
			grp_idx[g]   = '0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				if (active[g*GROUP_SIZE+k] &&
				    (!grp_found[g] || level[g*GROUP_SIZE+k] >= grp_lvl[g])) begin
					grp_found[g] = 1'b1;
					grp_lvl[g]   = level[g*GROUP_SIZE+k];
					grp_idx[g]   = SRC_IDX_W'(g*GROUP_SIZE+k);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_groups) begin
			grp_found_s1 <= grp_found;
			grp_lvl_s1   <= grp_lvl;
			grp_idx_s1   <= grp_idx;
		end
	end

	always_comb begin
		fin_found = 1'b0;
		fin_lvl   = '0;
		fin_idx   = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (grp_found_s1[g] && (!fin_found || grp_lvl_s1[g] >= fin_lvl)) begin
				fin_found = 1'b1;
				fin_lvl   = grp_lvl_s1[g];
				fin_idx   = grp_idx_s1[g];
			end
		end
	end

	// A level of zero never exceeds the mask, so it is never taken.
	always_comb begin
		result = '0;
		if (fin_found && !block_q && (fin_lvl > mask_q)) begin
			result.accept       = 1'b1;
			result.event_code   = SRC_CODE[fin_idx];
			result.winner       = fin_idx;
			result.winner_level = fin_lvl;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_q <= result;
		end
	end

	assign out_data = out_q;

endmodule

>>> rtl/priority_interrupt_controller_unit.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data (in_item_t)
// out      output     out_valid / out_ready  out_data (out_item_t)
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each item passes the bit update at the input transfer, the group
// search of the winner tree, then the final compare into the output register.
// The two levels of the winner tree, group and final, are each registered.
// A new item is taken once the previous result is in the output register.
// A stalled output holds the final stage; cfg is always ready.
// Reset clears pending bits and priorities and sets all enables.
module priority_interrupt_controller_unit import pic_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PRIO_W-1:0]    cfg_data
);

	pic_cmd_t cmd;

	assign cfg_ready = 1'b1;

	pic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	pic_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in flight");

	a_reject_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.accept) |->
		(out_data.event_code == '0 && out_data.winner == '0 &&
		 out_data.winner_level == '0))
		else $error("rejected result carries nonzero fields");

	a_accept_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.accept) |->
		(out_data.winner_level != '0 && out_data.winner < SRC_IDX_W'(NUM_SOURCES)))
		else $error("accepted result with level zero or bad source");

	a_no_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_result) |-> !in_ready)
		else $error("result loaded while idle");

endmodule
